@@ rtl/core/morse_code_keyer_defines.svh @@
// ============================================================================
// Morse code keyer assertion macros
// Shared assertion forms for the keyer RTL, clocked on clk and disabled
// during reset.
// ============================================================================
`ifndef MORSE_CODE_KEYER_DEFINES_SVH
`define MORSE_CODE_KEYER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCK_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("morse_code_keyer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("morse_code_keyer: next-cycle check failed");

`endif

@@ rtl/core/mck_pkg.sv @@
// ============================================================================
// Morse code keyer package
// Symbol table, character folding and symbol lookup shared by the keyer RTL.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    // Number of entries in the symbol table and widths derived from it.
    localparam int SYM_COUNT = 67;
    localparam int IDX_W     = 7;
    localparam int SYM_BITS  = 19;
    localparam int LEN_W     = 5;

    localparam logic [7:0]       CHAR_SPACE = 8'h20;
    localparam logic [LEN_W-1:0] GAP_LEN    = 5'd3;

    // Each word holds the length in bits 28:24 and the levels right aligned.
    localparam logic [31:0] SYM_TAB [SYM_COUNT] = '{
        32'h07000000, 32'h13075d77, 32'h0f005d5d, 32'h0f005555, 32'h11015757,
        32'h0f005555, 32'h0b0005d5, 32'h1305dddd, 32'h0f0075dd, 32'h13075dd7,
        32'h0b000757, 32'h0d00175d, 32'h13077577, 32'h0f007557, 32'h110175d7,
        32'h0d001d5d, 32'h13077777, 32'h11017777, 32'h0f005777, 32'h0d001577,
        32'h0b000557, 32'h09000155, 32'h0b000755, 32'h0d001dd5, 32'h0f007775,
        32'h1101dddd, 32'h1101ddd5, 32'h1101d75d, 32'h0f005555, 32'h0d001d57,
        32'h0f005555, 32'h0f005775, 32'h1101775d, 32'h05000017, 32'h090001d5,
        32'h0b00075d, 32'h07000075, 32'h01000001, 32'h0900015d, 32'h090001dd,
        32'h07000055, 32'h03000005, 32'h0d001777, 32'h090001d7, 32'h09000175,
        32'h07000077, 32'h0500001d, 32'h0b000777, 32'h0b0005dd, 32'h0d001dd7,
        32'h0700005d, 32'h05000015, 32'h03000007, 32'h07000057, 32'h09000157,
        32'h09000177, 32'h0b000757, 32'h0d001d77, 32'h0b000775, 32'h0f005555,
        32'h0f005555, 32'h0f005555, 32'h0f005555, 32'h11015dd7, 32'h03000000,
        32'h0f0075d7, 32'h0d00175d
    };

    // A symbol ready for serial output: levels left aligned, first level at the top.
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [SYM_BITS-1:0] bits;
    } sym_t;

    // Map a printable character to its table index; lowercase folds to uppercase.
    function automatic logic [IDX_W-1:0] fold_char(input logic [7:0] c);
        logic [7:0] idx;
        if (c > 8'h60)
        begin
            idx = c - 8'h40;
        end
        else
        begin
            idx = c - 8'h20;
        end
        return idx[IDX_W-1:0];
    endfunction

    // Read the table and left align the levels so they shift out from the top bit.
    function automatic sym_t sym_lookup(input logic [IDX_W-1:0] idx);
        logic [31:0] word;
        sym_t        sym;
        if (idx < IDX_W'(SYM_COUNT))
        begin
            word = SYM_TAB[idx];
        end
        else
        begin
            word = '0;
        end
        sym.len  = word[24 +: LEN_W];
        sym.bits = word[SYM_BITS-1:0] << (LEN_W'(SYM_BITS) - sym.len);
        return sym;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mck_if.sv @@
// ============================================================================
// Morse code keyer channels
// Valid/ready channels for message characters and for keying results.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// One character of a message per transfer.
interface mck_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last_in_message;

    modport source (output valid, output character, output last_in_message, input ready);
    modport sink   (input valid, input character, input last_in_message, output ready);
endinterface

// One key level or error result per transfer.
interface mck_key_if;
    logic valid;
    logic ready;
    logic key_level;
    logic status;
    logic end_of_message;
    logic last_of_run;

    modport source (output valid, output key_level, output status, output end_of_message,
                    output last_of_run, input ready);
    modport sink   (input valid, input key_level, input status, input end_of_message,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/core/morse_code_keyer.sv @@
// ============================================================================
// Morse code keyer
// Turns message characters into a serial stream of key levels with ITU
// timing, holding one character back to decide on letter gaps.
// ============================================================================
//
//  Channel | Direction | Payload
//  --------+-----------+------------------------------------------------------
//  msg     | in        | character[7:0], last_in_message
//  key     | out       | key_level, status, end_of_message, last_of_run
//
//  A character is taken while the sequencer is idle; the results it causes
//  then follow one per cycle while key does not stall, up to 41 for one
//  character, and a character that only becomes pending leaves it idle.
//  The symbol shift register moves one level per result.
//  Reset clears the pending character, the discard flag and the output valid.
//  A stall on key holds the sequencer; the next character is taken while the
//  final result of the previous one still waits in the output register.
//
`timescale 1ns / 1ps
`default_nettype none

module morse_code_keyer
(
    input  wire         clk,
    input  wire         rst_n,
    mck_msg_if.sink     msg,
    mck_key_if.source   key
);

`include "morse_code_keyer_defines.svh"

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PEND = 3'd1;
    localparam logic [2:0] S_GAP  = 3'd2;
    localparam logic [2:0] S_CUR  = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [7:0]                      pend_char_reg, pend_char_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic                            discard_reg, discard_next;
    logic [7:0]                      cur_char_reg, cur_char_next;
    logic                            last_reg, last_next;
    logic                            invalid_reg, invalid_next;
    logic                            gap_due_reg, gap_due_next;
    logic [mck_pkg::SYM_BITS-1:0]    sh_reg, sh_next;
    logic [mck_pkg::LEN_W-1:0]       cnt_reg, cnt_next;

    logic out_valid_reg, out_valid_next;
    logic key_reg, key_next;
    logic status_reg, status_next;
    logic eom_reg, eom_next;
    logic lor_reg, lor_next;

    logic          accept;
    logic          emit;
    logic          in_invalid;
    logic          fin;
    logic [7:0]    look_char;
    mck_pkg::sym_t look_sym;

    // Handshake: characters are taken only while the sequencer is idle.
    assign msg.ready = (state_reg == S_IDLE);
    assign accept    = msg.valid && msg.ready;

    // Outside idle, a result is produced whenever the output register is free or draining.
    assign emit = (state_reg != S_IDLE) && (!out_valid_reg || key.ready);
    assign fin  = (cnt_reg == mck_pkg::LEN_W'(1));

    assign in_invalid = msg.character[7] || (msg.character[7:5] == 3'b000);

    // One symbol lookup, shared by the accept cycle and the later load of
    // the current character.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            look_char = pend_valid_reg ? pend_char_reg : msg.character;
        end
        else
        begin
            look_char = cur_char_reg;
        end
        look_sym = mck_pkg::sym_lookup(mck_pkg::fold_char(look_char));
    end

    // Sequencer and output register next state.
    always_comb
    begin
        state_next      = state_reg;
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        discard_next    = discard_reg;
        cur_char_next   = cur_char_reg;
        last_next       = last_reg;
        invalid_next    = invalid_reg;
        gap_due_next    = gap_due_reg;
        sh_next         = sh_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !key.ready;
        key_next        = key_reg;
        status_next     = status_reg;
        eom_next        = eom_reg;
        lor_next        = lor_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (discard_reg)
                    begin
                        // Swallow the rest of an aborted message.
                        if (msg.last_in_message)
                        begin
                            discard_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cur_char_next = msg.character;
                        last_next     = msg.last_in_message;
                        invalid_next  = in_invalid;
                        gap_due_next  = pend_valid_reg
                                        && (pend_char_reg != mck_pkg::CHAR_SPACE)
                                        && (msg.character != mck_pkg::CHAR_SPACE);
                        sh_next       = look_sym.bits;
                        cnt_next      = look_sym.len;
                        if (!in_invalid && !msg.last_in_message)
                        begin
                            pend_char_next  = msg.character;
                            pend_valid_next = 1'b1;
                        end
                        else
                        begin
                            pend_valid_next = 1'b0;
                        end
                        if (in_invalid)
                        begin
                            discard_next = !msg.last_in_message;
                        end
                        if (pend_valid_reg)
                        begin
                            state_next = S_PEND;
                        end
                        else if (in_invalid)
                        begin
                            state_next = S_ERR;
                        end
                        else if (msg.last_in_message)
                        begin
                            state_next = S_CUR;
                        end
                    end
                end
            end
            S_PEND, S_GAP, S_CUR:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    key_next       = sh_reg[mck_pkg::SYM_BITS-1];
                    status_next    = 1'b0;
                    eom_next       = 1'b0;
                    lor_next       = 1'b0;
                    sh_next        = sh_reg << 1;
                    cnt_next       = cnt_reg - mck_pkg::LEN_W'(1);
                    if (fin)
                    begin
                        if (state_reg == S_PEND && gap_due_reg)
                        begin
                            sh_next    = '0;
                            cnt_next   = mck_pkg::GAP_LEN;
                            state_next = S_GAP;
                        end
                        else if (state_reg != S_CUR && invalid_reg)
                        begin
                            state_next = S_ERR;
                        end
                        else if (state_reg != S_CUR && last_reg)
                        begin
                            sh_next    = look_sym.bits;
                            cnt_next   = look_sym.len;
                            state_next = S_CUR;
                        end
                        else
                        begin
                            // Final result of this character's run.
                            eom_next   = (state_reg == S_CUR);
                            lor_next   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_ERR:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    key_next       = 1'b0;
                    status_next    = 1'b1;
                    eom_next       = 1'b1;
                    lor_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_char_reg  <= '0;
            pend_valid_reg <= 1'b0;
            discard_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_char_reg  <= pend_char_next;
            pend_valid_reg <= pend_valid_next;
            discard_reg    <= discard_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        cur_char_reg <= cur_char_next;
        last_reg     <= last_next;
        invalid_reg  <= invalid_next;
        gap_due_reg  <= gap_due_next;
        sh_reg       <= sh_next;
        cnt_reg      <= cnt_next;
        key_reg      <= key_next;
        status_reg   <= status_next;
        eom_reg      <= eom_next;
        lor_reg      <= lor_next;
    end

    // Output channel.
    assign key.valid          = out_valid_reg;
    assign key.key_level      = key_reg;
    assign key.status         = status_reg;
    assign key.end_of_message = eom_reg;
    assign key.last_of_run    = lor_reg;

    // An error result is a silent key, ends the message and ends the run.
    `MCK_ASSERT_SAME(a_err_result, out_valid_reg && status_reg,
                     !key_reg && eom_reg && lor_reg)
    // The end of a message is always the end of a run.
    `MCK_ASSERT_SAME(a_eom_ends_run, out_valid_reg && eom_reg, lor_reg)
    // A shifting state always has levels left to send.
    `MCK_ASSERT_SAME(a_cnt_live,
                     state_reg == S_PEND || state_reg == S_GAP || state_reg == S_CUR,
                     cnt_reg != '0)
    // A last character seen while discarding ends the discard without work.
    `MCK_ASSERT_NEXT(a_discard_end, accept && discard_reg && msg.last_in_message,
                     !discard_reg && state_reg == S_IDLE)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ============================================================================
// Morse code keyer testbench
// Sends messages of ASCII characters into the keyer and checks every key
// level, status and framing flag against a behavioral predictor. Directed
// messages cover the letter gap rules, case folding, the grave accent, DEL,
// characters without a code and invalid bytes. Random messages follow under
// four phases of idling and stalling, with one long output hold-off.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    // Status codes carried by a key result.
    localparam logic ST_KEY   = 1'b0;
    localparam logic ST_ABORT = 1'b1;

    // Characters and table slots with a special role in the keying rules.
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_FIRST = 8'h20;
    localparam logic [6:0] GAP_SLOT    = 7'h40;

    // Run length guard, in clock cycles.
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 60;

    // Length in bits 28:24, levels right aligned, first level at the top.
    localparam logic [31:0] CODE_WORDS [67] = '{
        32'h07000000, 32'h13075d77, 32'h0f005d5d, 32'h0f005555, 32'h11015757,
        32'h0f005555, 32'h0b0005d5, 32'h1305dddd, 32'h0f0075dd, 32'h13075dd7,
        32'h0b000757, 32'h0d00175d, 32'h13077577, 32'h0f007557, 32'h110175d7,
        32'h0d001d5d, 32'h13077777, 32'h11017777, 32'h0f005777, 32'h0d001577,
        32'h0b000557, 32'h09000155, 32'h0b000755, 32'h0d001dd5, 32'h0f007775,
        32'h1101dddd, 32'h1101ddd5, 32'h1101d75d, 32'h0f005555, 32'h0d001d57,
        32'h0f005555, 32'h0f005775, 32'h1101775d, 32'h05000017, 32'h090001d5,
        32'h0b00075d, 32'h07000075, 32'h01000001, 32'h0900015d, 32'h090001dd,
        32'h07000055, 32'h03000005, 32'h0d001777, 32'h090001d7, 32'h09000175,
        32'h07000077, 32'h0500001d, 32'h0b000777, 32'h0b0005dd, 32'h0d001dd7,
        32'h0700005d, 32'h05000015, 32'h03000007, 32'h07000057, 32'h09000157,
        32'h09000177, 32'h0b000757, 32'h0d001d77, 32'h0b000775, 32'h0f005555,
        32'h0f005555, 32'h0f005555, 32'h0f005555, 32'h11015dd7, 32'h03000000,
        32'h0f0075d7, 32'h0d00175d
    };

    typedef struct packed {
        logic key_level;
        logic status;
        logic end_of_message;
        logic last_of_run;
    } keying_t;

    // Predicts the key stream of each accepted character and checks results.
    class keyer_scoreboard;
        keying_t    expected_keys[$];
        logic [7:0] held_char;
        logic       held_valid;
        logic       discarding;
        int         errors;

        function new();
            held_char  = '0;
            held_valid = 1'b0;
            discarding = 1'b0;
            errors     = 0;
        endfunction

        // Lowercase folds onto uppercase; the rest shifts down by a space.
        function logic [6:0] table_slot(input logic [7:0] c);
            logic [7:0] slot;
            slot = (c > 8'h60) ? c - 8'h40 : c - 8'h20;
            return slot[6:0];
        endfunction

        function void push_code(input logic [6:0] slot);
            logic [31:0] word;
            int          len;
            word = CODE_WORDS[slot];
            len  = int'(word[28:24]);
            for (int i = len - 1; i >= 0; i--)
            begin
                expected_keys.push_back(keying_t'{word[i], ST_KEY, 1'b0, 1'b0});
            end
        endfunction

        // Notes an accepted character; returns 0 when it falls in a discard.
        function int take_char(input logic [7:0] c, input logic lst);
            int first;
            first = expected_keys.size();
            if (discarding)
            begin
                if (lst)
                begin
                    discarding = 1'b0;
                end
                return 0;
            end
            // The held character goes out now, with a letter gap between two
            // characters that are not spaces.
            if (held_valid)
            begin
                push_code(table_slot(held_char));
                if (held_char != ASCII_SPACE && c != ASCII_SPACE)
                begin
                    push_code(GAP_SLOT);
                end
                held_valid = 1'b0;
            end
            if (c < ASCII_FIRST || c[7])
            begin
                expected_keys.push_back(keying_t'{1'b0, ST_ABORT, 1'b1, 1'b0});
                discarding = !lst;
            end
            else if (lst)
            begin
                push_code(table_slot(c));
                expected_keys[$].end_of_message = 1'b1;
            end
            else
            begin
                held_char  = c;
                held_valid = 1'b1;
            end
            if (expected_keys.size() > first)
            begin
                expected_keys[$].last_of_run = 1'b1;
            end
            return 1;
        endfunction

        function void compare_field(input string name, input logic exp, input logic act);
            if (exp !== act)
            begin
                errors++;
                $display("%0t: %s expected %0b got %0b", $time, name, exp, act);
            end
        endfunction

        function void check_key(input keying_t got);
            keying_t exp;
            if (expected_keys.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none got %b", $time, got);
                return;
            end
            exp = expected_keys.pop_front();
            compare_field("key_level", exp.key_level, got.key_level);
            compare_field("status", exp.status, got.status);
            compare_field("end_of_message", exp.end_of_message, got.end_of_message);
            compare_field("last_of_run", exp.last_of_run, got.last_of_run);
        endfunction

        function int outstanding();
            return expected_keys.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_req;
    int   idle_pct;
    int   stall_pct;
    int   cycle_count;

    keyer_scoreboard keyer_sb = new();

    mck_msg_if msg_ch();
    mck_key_if key_ch();

    morse_code_keyer DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_ch),
        .key   (key_ch)
    );

    // Free running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Offers one character, idling first at the current rate; valid stays high
    // after the transfer so back to back characters keep it asserted.
    task automatic send_char(input logic [7:0] c, input logic lst, inout int counted);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid           <= 1'b1;
        msg_ch.character       <= c;
        msg_ch.last_in_message <= lst;
        do
        begin
            @(posedge clk);
        end
        while (!msg_ch.ready);
        counted += keyer_sb.take_char(c, lst);
    endtask

    // Mostly letters, digits and signs, some spaces, a few invalid bytes.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 7)
        begin
            return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                               : 8'($urandom_range(128, 255));
        end
        else if (pick < 22)
        begin
            return ASCII_SPACE;
        end
        return 8'($urandom_range(8'h21, 8'h7f));
    endfunction

    // Result side: checks each transfer and stalls at the current rate.
    initial
    begin : key_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        key_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (key_ch.valid && key_ch.ready)
            begin
                keyer_sb.check_key(keying_t'{key_ch.key_level, key_ch.status,
                                             key_ch.end_of_message, key_ch.last_of_run});
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                key_ch.ready <= 1'b0;
            end
            else
            begin
                key_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus: directed messages, then random messages in four phases.
    initial
    begin : stimulus
        int counted;
        int msg_len;
        counted                = 0;
        hold_req               <= 1'b0;
        idle_pct               = 0;
        stall_pct              = 0;
        msg_ch.valid           <= 1'b0;
        msg_ch.character       <= '0;
        msg_ch.last_in_message <= 1'b0;
        rst_n                  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single letter, then a mixed-case pair with a letter gap.
        send_char("E", 1'b1, counted);
        send_char("H", 1'b0, counted);
        send_char("i", 1'b1, counted);
        // A space suppresses the gap on both sides.
        send_char("a", 1'b0, counted);
        send_char(" ", 1'b0, counted);
        send_char("b", 1'b1, counted);
        // Grave accent keys as a letter space; DEL keys as underscore.
        send_char(8'h60, 1'b0, counted);
        send_char(8'h7f, 1'b1, counted);
        // A character without a code and a brace both key the error prosign.
        send_char("#", 1'b0, counted);
        send_char("{", 1'b1, counted);
        // A lone space as the whole message.
        send_char(" ", 1'b1, counted);
        // Invalid byte mid message after a letter: gap, abort, then discard.
        send_char("Z", 1'b0, counted);
        send_char(8'h00, 1'b0, counted);
        send_char("Q", 1'b0, counted);
        send_char("R", 1'b1, counted);
        // Invalid last byte after a space, so no gap.
        send_char(" ", 1'b0, counted);
        send_char(8'hff, 1'b1, counted);
        // Invalid byte opening a message.
        send_char(8'h80, 1'b1, counted);
        send_char(8'h1f, 1'b0, counted);
        send_char("x", 1'b1, counted);
        // Digits, with zero among the widest symbols.
        send_char("0", 1'b0, counted);
        send_char("9", 1'b1, counted);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 65; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            // The long output hold-off fills the block while input is offered.
            if (phase == 0)
            begin
                hold_req <= 1'b1;
            end
            counted = 0;
            while (counted < 38)
            begin
                msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10)
                                                      : $urandom_range(1, 5);
                for (int i = 0; i < msg_len; i++)
                begin
                    send_char(random_char(), i == msg_len - 1, counted);
                end
            end
        end
        msg_ch.valid <= 1'b0;

        // Drain all expected results, then watch for strays.
        while (keyer_sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (keyer_sb.errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mck_pkg.sv
rtl/core/mck_if.sv
rtl/core/morse_code_keyer.sv
tb/sv/testbench.sv
